// ===== rtl/core/rgb_3x3_convolution_filter_core_defines.svh =====
// assertion macros for the rgb 3x3 convolution filter core
`ifndef RGB_3X3_CONVOLUTION_FILTER_CORE_DEFINES_SVH
`define RGB_3X3_CONVOLUTION_FILTER_CORE_DEFINES_SVH

// condition and check in the same cycle
`define RCF_ASSERT_NOW(lbl, cond, chk) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (chk)) \
		else $error("rcf assertion failed");

// check in the cycle after the condition
`define RCF_ASSERT_NEXT(lbl, cond, chk) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (chk)) \
		else $error("rcf assertion failed");

`endif

// ===== rtl/core/rcf_pkg.sv =====
// types, constants and a helper function shared by the convolution filter core
`default_nettype none
package rcf_pkg;

	localparam int CH_W           = 8;
	localparam int NUM_CH         = 3;
	localparam int WIN_N          = 9;
	localparam int CFG_IDX_W      = 2;
	localparam int CFG_DATA_W     = 13;
	localparam int WIDTH_FIELD_W  = 11;
	localparam int HEIGHT_FIELD_W = 13;
	localparam int ROW_W          = 12;
	localparam int HEIGHT_LIMIT   = 4096;
	localparam int WIDTH_RESET    = 256;
	localparam int HEIGHT_RESET   = 256;
	localparam int MIN_DIM        = 3;
	localparam int SUM_W          = 12;
	localparam int CONV_W         = 13;
	localparam int BLUR_RECIP     = 7282;
	localparam int RECIP_SHIFT    = 16;
	localparam int PROD_W         = 25;
	localparam int QUEUE_DEPTH    = 4;
	localparam int QPTR_W         = 2;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_MODE   = 2'd0;
	localparam cfg_idx_t CFG_WIDTH  = 2'd1;
	localparam cfg_idx_t CFG_HEIGHT = 2'd2;

	typedef enum logic [1:0] {
		MODE_PASS    = 2'd0,
		MODE_BLUR    = 2'd1,
		MODE_SHARPEN = 2'd2,
		MODE_EDGE    = 2'd3
	} mode_t;

	// channel 2 red, 1 green, 0 blue
	typedef logic [NUM_CH-1:0][CH_W-1:0] pix_t;

	typedef struct packed {
		pix_t above1;
		pix_t above2;
	} ls_word_t;

	typedef struct packed {
		pix_t [WIN_N-1:0] win;
		logic             last;
	} job_t;

	function automatic logic [CH_W-1:0] clamp_byte(logic signed [CONV_W-1:0] v);
		logic [CH_W-1:0] r;
		if (v < 0) begin
			r = '0;
		end else if (v > 13'sd255) begin
			r = '1;
		end else begin
			r = v[CH_W-1:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/rcf_if.sv =====
// pixel stream interfaces for the input and result channels
`default_nettype none
interface rcf_pix_in_if;
	logic       valid;
	logic       ready;
	logic       frame_start;
	logic [7:0] in_red;
	logic [7:0] in_green;
	logic [7:0] in_blue;

	modport source(output valid, frame_start, in_red, in_green, in_blue, input ready);
	modport sink(input valid, frame_start, in_red, in_green, in_blue, output ready);
endinterface

interface rcf_pix_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_red;
	logic [7:0] out_green;
	logic [7:0] out_blue;
	logic       frame_last;

	modport source(output valid, out_red, out_green, out_blue, frame_last, input ready);
	modport sink(input valid, out_red, out_green, out_blue, frame_last, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/rgb_3x3_convolution_filter_core.sv =====
// top level of the rgb 3x3 convolution filter core
// Takes one RGB pixel per clock in raster order and returns one result per clock once
// the pipeline is full and not stalled: every pixel in pass-through mode, interior
// pixels only in blur, sharpen and edge modes. A pixel passes the input stage, job
// queue, back end and result registers. The line store, with one read on request and
// one write-back per cycle, sets that rate. The line stores are not cleared after
// reset, so the first two lines of the first frame should start with frame_start.
// Configuration must be written only while the core is idle; this is not enforced.
`default_nettype none
module rgb_3x3_convolution_filter_core #(
	parameter int MAX_WIDTH = 1024
) (
	input  wire                              clk,
	input  wire                              arst_n,
	rcf_pix_in_if.sink                       pix_in,
	rcf_pix_out_if.source                    pix_out,
	input  wire                              cfg_we,
	input  wire [rcf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire [rcf_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import rcf_pkg::*;

	mode_t                     mode_q;
	logic [WIDTH_FIELD_W-1:0]  width_q;
	logic [HEIGHT_FIELD_W-1:0] height_q;
	logic                      q_full, q_push, q_pop, q_empty;
	job_t                      q_wdata, q_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_PASS;
			width_q  <= WIDTH_FIELD_W'(WIDTH_RESET);
			height_q <= HEIGHT_FIELD_W'(HEIGHT_RESET);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MODE:   mode_q   <= mode_t'(cfg_data[1:0]);
				CFG_WIDTH:  width_q  <= cfg_data[WIDTH_FIELD_W-1:0];
				CFG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	rcf_front #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.pix_in      (pix_in),
		.mode        (mode_q),
		.image_width (width_q),
		.image_height(height_q),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_data      (q_wdata)
	);

	rcf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data(q_wdata),
		.full     (q_full),
		.pop      (q_pop),
		.pop_data (q_rdata),
		.empty    (q_empty)
	);

	rcf_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.mode   (mode_q),
		.q_empty(q_empty),
		.q_data (q_rdata),
		.q_pop  (q_pop),
		.pix_out(pix_out)
	);

endmodule
`default_nettype wire

// ===== rtl/core/rcf_front.sv =====
// front end: position counters, line stores and 3x3 window, pushes jobs to the queue
`default_nettype none
module rcf_front #(
	parameter int MAX_WIDTH = 1024
) (
	input  wire                                    clk,
	input  wire                                    arst_n,
	rcf_pix_in_if.sink                             pix_in,
	input  rcf_pkg::mode_t                         mode,
	input  wire [rcf_pkg::WIDTH_FIELD_W-1:0]       image_width,
	input  wire [rcf_pkg::HEIGHT_FIELD_W-1:0]      image_height,
	input  wire                                    q_full,
	output logic                                   q_push,
	output rcf_pkg::job_t                          q_data
);
	import rcf_pkg::*;

	localparam int CW = (MAX_WIDTH > 4) ? $clog2(MAX_WIDTH) : 2;
	localparam int WW = (CW + 1 > WIDTH_FIELD_W) ? CW + 1 : WIDTH_FIELD_W;

	logic [WW-1:0]             w_ext, wdt, wdt_m1, col_inc;
	logic [HEIGHT_FIELD_W-1:0] hgt, hgt_m1, row_inc;
	logic [CW-1:0]             col_q, col_cur, col_s1;
	logic [ROW_W-1:0]          row_q, row_cur;
	logic                      accept, col_wrap, row_wrap, last_cur, emit_cur;
	logic                      s1_valid_q, s1_adv, last_s1, emit_s1;
	pix_t                      pix_in_w, pix_s1, up1_eff, up2_eff;
	ls_word_t                  ls_mem [MAX_WIDTH];
	ls_word_t                  ls_rd_q, byp_q;
	logic                      byp_sel_q;
	pix_t [WIN_N-1:0]          win_q, win_nxt;

	assign w_ext = WW'(image_width);
	always_comb begin
		if (w_ext < WW'(MIN_DIM)) begin
			wdt = WW'(MIN_DIM);
		end else if (w_ext > WW'(MAX_WIDTH)) begin
			wdt = WW'(MAX_WIDTH);
		end else begin
			wdt = w_ext;
		end
		if (image_height < HEIGHT_FIELD_W'(MIN_DIM)) begin
			hgt = HEIGHT_FIELD_W'(MIN_DIM);
		end else if (image_height > HEIGHT_FIELD_W'(HEIGHT_LIMIT)) begin
			hgt = HEIGHT_FIELD_W'(HEIGHT_LIMIT);
		end else begin
			hgt = image_height;
		end
	end
	assign wdt_m1 = wdt - WW'(1);
	assign hgt_m1 = hgt - HEIGHT_FIELD_W'(1);

	assign accept   = pix_in.valid && pix_in.ready;
	assign pix_in_w = {pix_in.in_red, pix_in.in_green, pix_in.in_blue};
	assign col_cur  = pix_in.frame_start ? '0 : col_q;
	assign row_cur  = pix_in.frame_start ? '0 : row_q;
	assign col_inc  = WW'(col_cur) + WW'(1);
	assign row_inc  = HEIGHT_FIELD_W'(row_cur) + HEIGHT_FIELD_W'(1);
	assign col_wrap = col_inc >= wdt;
	assign row_wrap = row_inc >= hgt;
	assign last_cur = (WW'(col_cur) == wdt_m1) && (HEIGHT_FIELD_W'(row_cur) == hgt_m1);
	assign emit_cur = (mode == MODE_PASS) ||
		((col_cur >= CW'(2)) && (row_cur >= ROW_W'(2)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_wrap) begin
				col_q <= '0;
				row_q <= row_wrap ? '0 : row_inc[ROW_W-1:0];
			end else begin
				col_q <= col_inc[CW-1:0];
				row_q <= row_cur;
			end
		end
	end

	assign s1_adv       = s1_valid_q && (!emit_s1 || !q_full);
	assign pix_in.ready = !s1_valid_q || s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			byp_sel_q  <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
				byp_sel_q  <= s1_adv && (col_cur == col_s1);
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1  <= pix_in_w;
			col_s1  <= col_cur;
			last_s1 <= last_cur;
			emit_s1 <= emit_cur;
			byp_q   <= '{above1: pix_s1, above2: up1_eff};
		end
	end

	// line store: read on request, write back when the pixel leaves s1
	always_ff @(posedge clk) begin
		if (accept) begin
			ls_rd_q <= ls_mem[col_cur];
		end
		if (s1_adv) begin
			ls_mem[col_s1] <= '{above1: pix_s1, above2: up1_eff};
		end
	end

	assign up1_eff = byp_sel_q ? byp_q.above1 : ls_rd_q.above1;
	assign up2_eff = byp_sel_q ? byp_q.above2 : ls_rd_q.above2;

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			win_nxt[r*3]     = win_q[r*3+1];
			win_nxt[r*3 + 1] = win_q[r*3+2];
		end
		win_nxt[2] = up2_eff;
		win_nxt[5] = up1_eff;
		win_nxt[8] = pix_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (s1_adv) begin
			win_q <= win_nxt;
		end
	end

	assign q_push = s1_adv && emit_s1;
	assign q_data = '{win: win_nxt, last: last_s1};

endmodule
`default_nettype wire

// ===== rtl/core/rcf_queue.sv =====
// small job queue between the front end and the arithmetic back end
`default_nettype none
module rcf_queue (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            push,
	input  rcf_pkg::job_t  push_data,
	output logic           full,
	input  wire            pop,
	output rcf_pkg::job_t  pop_data,
	output logic           empty
);
	import rcf_pkg::*;

	job_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QPTR_W:0]   cnt_q;

	assign full     = cnt_q == (QPTR_W + 1)'(QUEUE_DEPTH);
	assign empty    = cnt_q == '0;
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full) begin
				wr_q <= wr_q + QPTR_W'(1);
			end
			if (pop && !empty) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
			case ({push && !full, pop && !empty})
				2'b10:   cnt_q <= cnt_q + (QPTR_W + 1)'(1);
				2'b01:   cnt_q <= cnt_q - (QPTR_W + 1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/rcf_back.sv =====
// back end: per channel convolution, blur divide, clamp and result register
`default_nettype none
module rcf_back (
	input  wire             clk,
	input  wire             arst_n,
	input  rcf_pkg::mode_t  mode,
	input  wire             q_empty,
	input  rcf_pkg::job_t   q_data,
	output logic            q_pop,
	rcf_pix_out_if.source   pix_out
);
	import rcf_pkg::*;

	logic                     en, b1_valid_q, last_b1, out_valid_q, last_q;
	mode_t                    mode_b1;
	logic signed [CONV_W-1:0] val_c [NUM_CH];
	logic [SUM_W-1:0]         sum_c [NUM_CH];
	logic signed [CONV_W-1:0] val_b1 [NUM_CH];
	logic [SUM_W-1:0]         sum_b1 [NUM_CH];
	logic [PROD_W-1:0]        prod [NUM_CH];
	logic [CH_W-1:0]          res [NUM_CH];
	logic [CH_W-1:0]          res_q [NUM_CH];

	assign en    = !out_valid_q || pix_out.ready;
	assign q_pop = en && !q_empty;

	always_comb begin
		logic signed [CONV_W-1:0] c, n, s, w, e;
		for (int ch = 0; ch < NUM_CH; ch++) begin
			c = $signed(CONV_W'(q_data.win[4][ch]));
			n = $signed(CONV_W'(q_data.win[1][ch]));
			s = $signed(CONV_W'(q_data.win[7][ch]));
			w = $signed(CONV_W'(q_data.win[3][ch]));
			e = $signed(CONV_W'(q_data.win[5][ch]));
			sum_c[ch] = '0;
			for (int k = 0; k < WIN_N; k++) begin
				sum_c[ch] = sum_c[ch] + SUM_W'(q_data.win[k][ch]);
			end
			case (mode)
				MODE_SHARPEN: val_c[ch] = (c <<< 2) + c - n - s - w - e;
				MODE_EDGE:    val_c[ch] = n + s + w + e - (c <<< 2);
				default:      val_c[ch] = $signed(CONV_W'(q_data.win[8][ch]));
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			val_b1  <= val_c;
			sum_b1  <= sum_c;
			mode_b1 <= mode;
			last_b1 <= q_data.last;
		end
	end

	always_comb begin
		for (int ch = 0; ch < NUM_CH; ch++) begin
			prod[ch] = PROD_W'(sum_b1[ch]) * PROD_W'(BLUR_RECIP);
			if (mode_b1 == MODE_BLUR) begin
				res[ch] = prod[ch][RECIP_SHIFT +: CH_W];
			end else begin
				res[ch] = clamp_byte(val_b1[ch]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			b1_valid_q  <= !q_empty;
			out_valid_q <= b1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (en && b1_valid_q) begin
			res_q  <= res;
			last_q <= last_b1;
		end
	end

	assign pix_out.valid      = out_valid_q;
	assign pix_out.out_red    = res_q[2];
	assign pix_out.out_green  = res_q[1];
	assign pix_out.out_blue   = res_q[0];
	assign pix_out.frame_last = last_q;

endmodule
`default_nettype wire

// ===== rtl/core/rcf_checker.sv =====
// port level checks for the convolution filter core and their binding
`default_nettype none
`include "rgb_3x3_convolution_filter_core_defines.svh"
module rcf_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       in_valid,
	input wire       in_ready,
	input wire       out_valid,
	input wire       out_ready,
	input wire [7:0] out_red,
	input wire [7:0] out_green,
	input wire [7:0] out_blue,
	input wire       frame_last
);
	logic        in_acc, out_acc;
	logic [15:0] pend_q;
	logic [24:0] out_pay;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;
	assign out_pay = {out_red, out_green, out_blue, frame_last};

	// requests taken minus results delivered, sticks once saturated
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (pend_q != '1) begin
			if (in_acc && !out_acc) begin
				pend_q <= pend_q + 16'd1;
			end else if (out_acc && !in_acc && pend_q != '0) begin
				pend_q <= pend_q - 16'd1;
			end
		end
	end

	`RCF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
	`RCF_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_pay))
	`RCF_ASSERT_NOW(a_out_has_request, out_acc, pend_q != '0)
	`RCF_ASSERT_NOW(a_idle_ready, pend_q == '0, in_ready)

endmodule

bind rgb_3x3_convolution_filter_core rcf_checker u_rcf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (pix_in.valid),
	.in_ready  (pix_in.ready),
	.out_valid (pix_out.valid),
	.out_ready (pix_out.ready),
	.out_red   (pix_out.out_red),
	.out_green (pix_out.out_green),
	.out_blue  (pix_out.out_blue),
	.frame_last(pix_out.frame_last)
);
`default_nettype wire

// ===== tb/testbench.sv =====
// self-checking testbench for the rgb 3x3 convolution filter core
module testbench;
	import rcf_pkg::*;

	localparam int LINE_MAX      = 1024;
	localparam int SETTLE_CYCLES = 8;
	localparam int STALL_LIMIT   = 2000;

	typedef struct packed {
		pix_t px;
		logic last;
	} out_pix_t;

	typedef struct {
		bit          is_cfg;
		cfg_idx_t    reg_idx;
		int unsigned reg_val;
		logic        fs;
		pix_t        px;
		bit          typed;
		out_pix_t    want;
	} step_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	cfg_idx_t              cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	rcf_pix_in_if  pix_in_ch ();
	rcf_pix_out_if pix_out_ch ();

	rgb_3x3_convolution_filter_core #(.MAX_WIDTH(LINE_MAX)) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_in    (pix_in_ch),
		.pix_out   (pix_out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// shadow copy of the core state
	pix_t                      above1_mem [LINE_MAX];
	pix_t                      above2_mem [LINE_MAX];
	pix_t                      win [WIN_N];
	int unsigned               col_pos;
	int unsigned               row_pos;
	mode_t                     mode_sh;
	logic [WIDTH_FIELD_W-1:0]  width_sh;
	logic [HEIGHT_FIELD_W-1:0] height_sh;

	out_pix_t out_pixels_due [$];
	int       src_idle_pct;
	int       sink_stall_pct;
	int       mismatches;
	int       pixels_sent;
	int       pixels_checked;
	int       stall_cycles;
	int       settings_run;

	function automatic logic [CH_W-1:0] convolve_channel(int ch);
		int c, n, s, w, e, acc;
		c = int'(win[4][ch]);
		n = int'(win[1][ch]);
		s = int'(win[7][ch]);
		w = int'(win[3][ch]);
		e = int'(win[5][ch]);
		acc = 0;
		case (mode_sh)
			MODE_BLUR: begin
				for (int k = 0; k < WIN_N; k++) acc = acc + int'(win[k][ch]);
				acc = acc / 9;
			end
			MODE_SHARPEN: acc = 5 * c - n - s - w - e;
			default: acc = n + s + w + e - 4 * c;
		endcase
		if (acc < 0) return '0;
		if (acc > 255) return '1;
		return acc[CH_W-1:0];
	endfunction

	function automatic bit apply_filter(input logic fs, input pix_t px, output out_pix_t res);
		int unsigned wdt, hgt;
		pix_t        up1, up2;
		bit          produced;
		wdt = (width_sh < MIN_DIM) ? MIN_DIM : (width_sh > LINE_MAX) ? LINE_MAX : width_sh;
		hgt = (height_sh < MIN_DIM) ? MIN_DIM :
			(height_sh > HEIGHT_LIMIT) ? HEIGHT_LIMIT : height_sh;
		if (fs) begin
			col_pos = 0;
			row_pos = 0;
		end
		up1 = above1_mem[col_pos];
		up2 = above2_mem[col_pos];
		above2_mem[col_pos] = up1;
		above1_mem[col_pos] = px;
		for (int r = 0; r < 3; r++) begin
			win[r * 3]     = win[r * 3 + 1];
			win[r * 3 + 1] = win[r * 3 + 2];
		end
		win[2] = up2;
		win[5] = up1;
		win[8] = px;
		res.px   = px;
		res.last = (col_pos == wdt - 1) && (row_pos == hgt - 1);
		produced = 1'b0;
		if (mode_sh == MODE_PASS) begin
			produced = 1'b1;
		end else if (col_pos >= 2 && row_pos >= 2) begin
			for (int ch = 0; ch < NUM_CH; ch++) res.px[ch] = convolve_channel(ch);
			produced = 1'b1;
		end
		col_pos++;
		if (col_pos >= wdt) begin
			col_pos = 0;
			row_pos++;
			if (row_pos >= hgt) row_pos = 0;
		end
		return produced;
	endfunction

	function automatic pix_t random_pixel();
		pix_t px;
		for (int ch = 0; ch < NUM_CH; ch++) begin
			case ($urandom_range(3))
				0: px[ch] = '0;
				1: px[ch] = '1;
				default: px[ch] = CH_W'($urandom_range(255));
			endcase
		end
		return px;
	endfunction

	function automatic step_t cfg_row(cfg_idx_t idx, int unsigned val);
		return '{1'b1, idx, val, 1'b0, pix_t'(0), 1'b0, out_pix_t'(0)};
	endfunction

	function automatic step_t px_row(logic fs, logic [7:0] r, logic [7:0] g, logic [7:0] b);
		return '{1'b0, CFG_MODE, 0, fs, pix_t'({r, g, b}), 1'b0, out_pix_t'(0)};
	endfunction

	// pixel whose result is the pixel itself
	function automatic step_t px_echo(logic fs, logic [7:0] r, logic [7:0] g, logic [7:0] b,
			logic last);
		return '{1'b0, CFG_MODE, 0, fs, pix_t'({r, g, b}), 1'b1,
			out_pix_t'({r, g, b, last})};
	endfunction

	task automatic settle();
		pix_in_ch.valid <= 1'b0;
		while (out_pixels_due.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input int unsigned val);
		settle();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val[CFG_DATA_W-1:0];
		case (idx)
			CFG_MODE: mode_sh = mode_t'(val[1:0]);
			CFG_WIDTH: width_sh = val[WIDTH_FIELD_W-1:0];
			CFG_HEIGHT: height_sh = val[HEIGHT_FIELD_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic push_pixel(input logic fs, input pix_t px, input bit typed,
			input out_pix_t want);
		out_pix_t got;
		while ($urandom_range(99) < src_idle_pct) begin
			pix_in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		pix_in_ch.valid       <= 1'b1;
		pix_in_ch.frame_start <= fs;
		pix_in_ch.in_red      <= px[2];
		pix_in_ch.in_green    <= px[1];
		pix_in_ch.in_blue     <= px[0];
		// hold the request until the core takes it
		@(posedge clk);
		while (pix_in_ch.ready !== 1'b1) @(posedge clk);
		if (apply_filter(fs, px, got)) out_pixels_due = {out_pixels_due, (typed ? want : got)};
		pixels_sent++;
		@(negedge clk);
	endtask

	always @(negedge clk) pix_out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);

	always @(posedge clk) begin : check_results
		out_pix_t want;
		if ((pix_in_ch.valid && pix_in_ch.ready) || (pix_out_ch.valid && pix_out_ch.ready)) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
			if (stall_cycles == STALL_LIMIT) begin
				$display("no request moved for %0d cycles", STALL_LIMIT);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
		if (arst_n && pix_out_ch.valid && pix_out_ch.ready) begin
			if (out_pixels_due.size() == 0) begin
				$error("unexpected result: red %0d green %0d blue %0d frame_last %0b",
					pix_out_ch.out_red, pix_out_ch.out_green, pix_out_ch.out_blue,
					pix_out_ch.frame_last);
				mismatches++;
			end else begin
				want = out_pixels_due.pop_front();
				pixels_checked++;
				if (pix_out_ch.out_red !== want.px[2]) begin
					$error("out_red expected %0d got %0d", want.px[2], pix_out_ch.out_red);
					mismatches++;
				end
				if (pix_out_ch.out_green !== want.px[1]) begin
					$error("out_green expected %0d got %0d", want.px[1], pix_out_ch.out_green);
					mismatches++;
				end
				if (pix_out_ch.out_blue !== want.px[0]) begin
					$error("out_blue expected %0d got %0d", want.px[0], pix_out_ch.out_blue);
					mismatches++;
				end
				if (pix_out_ch.frame_last !== want.last) begin
					$error("frame_last expected %0b got %0b", want.last, pix_out_ch.frame_last);
					mismatches++;
				end
			end
		end
	end

	initial begin
		step_t plan [$];
		int    w, h, count;
		mode_t mode;
		bit    restart;
		arst_n                = 1'b0;
		cfg_we                = 1'b0;
		cfg_index             = CFG_MODE;
		cfg_data              = '0;
		pix_in_ch.valid       = 1'b0;
		pix_in_ch.frame_start = 1'b0;
		pix_in_ch.in_red      = '0;
		pix_in_ch.in_green    = '0;
		pix_in_ch.in_blue     = '0;
		pix_out_ch.ready      = 1'b0;
		src_idle_pct          = 0;
		sink_stall_pct        = 0;
		mismatches            = 0;
		pixels_sent           = 0;
		pixels_checked        = 0;
		stall_cycles          = 0;
		settings_run          = 0;
		foreach (win[k]) win[k] = '0;
		col_pos   = 0;
		row_pos   = 0;
		mode_sh   = MODE_PASS;
		width_sh  = WIDTH_FIELD_W'(WIDTH_RESET);
		height_sh = HEIGHT_FIELD_W'(HEIGHT_RESET);

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// 3x6 frame: blur, sharpen and edge on one interior pixel each, then a passed row
		plan = '{
			px_echo(1'b1, 8'd255, 8'd0, 8'd255, 1'b0),
			px_echo(1'b0, 8'd0, 8'd255, 8'd0, 1'b0),
			cfg_row(CFG_WIDTH, 0),
			cfg_row(CFG_HEIGHT, 6),
			cfg_row(CFG_MODE, MODE_BLUR),
			px_row(1'b1, 8'd255, 8'd255, 8'd255),
			px_row(1'b0, 8'd255, 8'd255, 8'd255),
			px_row(1'b0, 8'd255, 8'd255, 8'd255),
			px_row(1'b0, 8'd255, 8'd255, 8'd255),
			px_row(1'b0, 8'd255, 8'd255, 8'd255),
			px_row(1'b0, 8'd255, 8'd255, 8'd255),
			px_row(1'b0, 8'd255, 8'd255, 8'd255),
			px_row(1'b0, 8'd255, 8'd255, 8'd255),
			px_echo(1'b0, 8'd255, 8'd255, 8'd255, 1'b0),
			cfg_row(CFG_MODE, MODE_SHARPEN),
			px_row(1'b0, 8'd0, 8'd0, 8'd0),
			px_row(1'b0, 8'd255, 8'd128, 8'd0),
			px_row(1'b0, 8'd0, 8'd0, 8'd0),
			cfg_row(CFG_MODE, MODE_EDGE),
			px_row(1'b0, 8'd1, 8'd2, 8'd3),
			px_row(1'b0, 8'd90, 8'd200, 8'd7),
			px_row(1'b0, 8'd255, 8'd255, 8'd255),
			cfg_row(CFG_MODE, MODE_PASS),
			px_echo(1'b0, 8'd0, 8'd0, 8'd0, 1'b0),
			px_echo(1'b0, 8'd255, 8'd255, 8'd255, 1'b0),
			px_echo(1'b0, 8'd18, 8'd52, 8'd86, 1'b1),
			// wraps to the next frame with no frame start
			px_echo(1'b0, 8'd128, 8'd64, 8'd32, 1'b0),
			px_echo(1'b1, 8'd7, 8'd7, 8'd7, 1'b0)
		};
		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				write_reg(plan[i].reg_idx, plan[i].reg_val);
			end else begin
				push_pixel(plan[i].fs, plan[i].px, plan[i].typed, plan[i].want);
			end
		end

		for (int ph = 0; ph < 16; ph++) begin
			mode    = (ph < 4) ? mode_t'(ph) : mode_t'($urandom_range(3));
			w       = $urandom_range(3, 10);
			h       = $urandom_range(3, 7);
			count   = 45;
			restart = 1'b1;
			case (ph)
				5: w = $urandom_range(0, 2);
				6: h = $urandom_range(0, 2);
				9: begin
					// widest line setting, clamped to the line store size
					mode = MODE_PASS;
					w    = 2047;
					h    = 2;
				end
				10: h = 8191;
				// narrower line picked up mid-frame
				13: begin
					w       = 3;
					restart = 1'b0;
				end
				default: ;
			endcase
			write_reg(CFG_MODE, mode);
			write_reg(CFG_WIDTH, w);
			write_reg(CFG_HEIGHT, h);
			src_idle_pct   = (ph % 4 == 1) ? 72 : (ph % 4 == 3) ? 24 : 0;
			sink_stall_pct = (ph % 4 == 2) ? 72 : (ph % 4 == 3) ? 24 : 0;
			for (int k = 0; k < count; k++) begin
				push_pixel((restart && k == 0) || (w <= 64 && $urandom_range(99) < 2),
					random_pixel(), 1'b0, out_pix_t'(0));
			end
			settings_run++;
		end
		settle();

		$display("%0d pixels sent, %0d results checked over %0d random filter settings",
			pixels_sent, pixels_checked, settings_run);
		$display("all four modes, clamped sizes, frame wrap and mid-frame restarts under stalls");
		if (mismatches == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
